// ===== hw/rtl/srfr_pkg.sv =====
// Shared types and codes for the sync/length frame receiver.
`default_nettype none

package srfr_pkg;

	// default frame store size in bytes
	localparam int STORE_BYTES = 64;

	// configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;

	// request types
	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DISCARD  = 3'd0;
	localparam logic [2:0] ST_SYNC     = 3'd1;
	localparam logic [2:0] ST_STORED   = 3'd2;
	localparam logic [2:0] ST_COMPLETE = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;
	localparam logic [2:0] ST_READ     = 3'd6;
	localparam logic [2:0] ST_RELEASED = 3'd7;

	// receiver phases
	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_SYNC    = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] byte_value;
		logic [5:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_data;
		logic [6:0] frame_total;
		logic       frame_ready;
	} out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sync_length_frame_receiver.sv =====
// Top level: two-byte sync hunt, length-prefixed frame capture and store readback.
// Each result passes through a decode stage, then an output register.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled output holds both stages; input ready drops only when both stages are full.
// Reset (arst_n low, asynchronous): hunting phase, write position 0, pipeline empty,
// sync bytes back to 0xA5 / 0x5A. Frame store contents are not cleared.
`default_nettype none

module sync_length_frame_receiver #(
	parameter int STORE_BYTES = srfr_pkg::STORE_BYTES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire srfr_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output srfr_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [srfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [7:0]                         cfg_data
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

	// configuration and receiver state
	logic [7:0]    sync1_q, sync2_q;
	logic [1:0]    phase_q, phase_d;
	logic [AW-1:0] wpos_q, wpos_d;
	logic [7:0]    len_q, len_d;

	// pipeline
	logic                v_s1, v_s2;
	srfr_pkg::out_item_t res_s1, res_d, out_d, out_q;
	logic                rd_ram_s1;

	logic          acc, adv;
	logic          we_c, rd_ram_c, rd_len_c;
	logic [2:0]    status_c;
	logic [CW-1:0] total_w;
	logic [AW:0]   wp_inc;
	logic [7:0]    len_eff;
	logic          in_range;
	logic [7:0]    ram_rdata;

	assign cfg_ready = 1'b1;
	assign adv       = !v_s2 || out_ready;
	assign in_ready  = !v_s1 || adv;
	assign acc       = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync1_q <= srfr_pkg::SYNC_FIRST_RST;
			sync2_q <= srfr_pkg::SYNC_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == srfr_pkg::CFG_SYNC_FIRST) begin
				sync1_q <= cfg_data;
			end else if (cfg_index == srfr_pkg::CFG_SYNC_SECOND) begin
				sync2_q <= cfg_data;
			end
		end
	end

	// per-transaction decode and next state
	assign wp_inc   = {1'b0, wpos_q} + (AW + 1)'(1);
	assign len_eff  = (wpos_q == AW'(1)) ? in_data.byte_value : len_q;
	assign in_range = CW'(in_data.read_index) < CW'(STORE_BYTES);

	always_comb begin
		phase_d  = phase_q;
		wpos_d   = wpos_q;
		len_d    = len_q;
		status_c = srfr_pkg::ST_IGNORED;
		total_w  = CW'(wpos_q);
		we_c     = 1'b0;
		rd_ram_c = 1'b0;
		rd_len_c = 1'b0;
		case (in_data.req_type)
			srfr_pkg::REQ_BYTE: begin
				case (phase_q)
					srfr_pkg::PH_HUNT: begin
						if (in_data.byte_value == sync1_q) begin
							phase_d  = srfr_pkg::PH_SYNC;
							status_c = srfr_pkg::ST_SYNC;
						end else begin
							status_c = srfr_pkg::ST_DISCARD;
						end
					end
					srfr_pkg::PH_SYNC: begin
						if (in_data.byte_value == sync2_q) begin
							phase_d  = srfr_pkg::PH_COLLECT;
							status_c = srfr_pkg::ST_SYNC;
						end else begin
							phase_d  = srfr_pkg::PH_HUNT;
							status_c = srfr_pkg::ST_DISCARD;
						end
					end
					srfr_pkg::PH_COLLECT: begin
						we_c    = 1'b1;
						total_w = CW'(wp_inc);
						// the length byte lives in its own register as well
						if (wpos_q == AW'(1)) begin
							len_d = in_data.byte_value;
						end
						if (wp_inc > (AW + 1)'(1) &&
							CW'(wp_inc) >= CW'(len_eff) + CW'(2)) begin
							phase_d  = srfr_pkg::PH_DONE;
							wpos_d   = '0;
							status_c = srfr_pkg::ST_COMPLETE;
						end else if (CW'(wp_inc) >= CW'(STORE_BYTES)) begin
							len_d    = '0;
							phase_d  = srfr_pkg::PH_HUNT;
							wpos_d   = '0;
							status_c = srfr_pkg::ST_OVERFLOW;
						end else begin
							wpos_d   = wp_inc[AW-1:0];
							status_c = srfr_pkg::ST_STORED;
						end
					end
					default: begin
						status_c = srfr_pkg::ST_IGNORED;
					end
				endcase
			end
			srfr_pkg::REQ_READ: begin
				status_c = srfr_pkg::ST_READ;
				// the length entry is served from its register
				if (in_range) begin
					if (in_data.read_index == 6'd1) begin
						rd_len_c = 1'b1;
					end else begin
						rd_ram_c = 1'b1;
					end
				end
			end
			srfr_pkg::REQ_RELEASE: begin
				status_c = srfr_pkg::ST_RELEASED;
				if (phase_q == srfr_pkg::PH_DONE) begin
					len_d   = '0;
					phase_d = srfr_pkg::PH_HUNT;
					wpos_d  = '0;
					total_w = '0;
				end
			end
			default: begin
				status_c = srfr_pkg::ST_IGNORED;
			end
		endcase
	end

	always_comb begin
		res_d.status      = status_c;
		res_d.read_data   = rd_len_c ? len_q : 8'd0;
		res_d.frame_total = total_w[6:0];
		res_d.frame_ready = (phase_d == srfr_pkg::PH_DONE);
	end

	// receiver state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= srfr_pkg::PH_HUNT;
			wpos_q  <= '0;
			len_q   <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			wpos_q  <= wpos_d;
			len_q   <= len_d;
		end
	end

	// frame store
	srfr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (acc && we_c),
		.waddr (wpos_q),
		.wdata (in_data.byte_value),
		.re    (acc && rd_ram_c),
		.raddr (AW'(CW'(in_data.read_index))),
		.rdata (ram_rdata)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	// output value: store data merged in for store reads
	always_comb begin
		out_d           = res_s1;
		out_d.read_data = rd_ram_s1 ? ram_rdata : res_s1.read_data;
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1    <= res_d;
			rd_ram_s1 <= rd_ram_c;
		end
		if (adv && v_s1) begin
			out_q <= out_d;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = out_q;

	// write position only moves while collecting
	a_wpos_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(wpos_q != '0) |-> (phase_q == srfr_pkg::PH_COLLECT))
		else $error("write position nonzero outside collecting phase");

	// a stalled decode stage keeps its result
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(res_s1)))
		else $error("decode stage result lost while stalled");

	// completion always leaves the frame locked
	a_complete_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && res_s1.status == srfr_pkg::ST_COMPLETE) |-> res_s1.frame_ready)
		else $error("complete status without frame ready");

	// received bytes are ignored while locked
	a_locked_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == srfr_pkg::PH_DONE && in_data.req_type == srfr_pkg::REQ_BYTE)
		|=> (res_s1.status == srfr_pkg::ST_IGNORED && phase_q == srfr_pkg::PH_DONE))
		else $error("byte not ignored while frame locked");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the sync/length frame receiver: directed and random streams.

module tb;
	import srfr_pkg::*;

	// request type with no defined meaning, answered as ignored
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int PIPE_DEPTH = 2;
	localparam int QUIET_LIMIT = 4000;
	localparam int CHUNK_ITEMS = 250;
	localparam int CHUNK_COUNT = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
	logic [7:0] cfg_data = '0;

	// bench bookkeeping
	in_item_t pending_items[$];
	out_item_t expected_results[$];
	logic in_taken = 1'b0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	// receiver state as the bench sees it
	logic [1:0] rx_phase = PH_HUNT;
	int wr_pos = 0;
	logic [7:0] store_model [STORE_BYTES];
	logic [7:0] sync_first_q = SYNC_FIRST_RST;
	logic [7:0] sync_second_q = SYNC_SECOND_RST;

	// sync bytes the stimulus is built around
	logic [7:0] gen_first = SYNC_FIRST_RST;
	logic [7:0] gen_second = SYNC_SECOND_RST;

	sync_length_frame_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// advance the receiver by one transaction and queue the result it should give
	function automatic void step_receiver(input in_item_t item);
		out_item_t res;
		int total;
		res = '0;
		res.status = ST_IGNORED;
		total = wr_pos;
		case (item.req_type)
			REQ_BYTE: begin
				case (rx_phase)
					PH_HUNT: begin
						if (item.byte_value == sync_first_q) begin
							rx_phase = PH_SYNC;
							res.status = ST_SYNC;
						end else begin
							res.status = ST_DISCARD;
						end
					end
					PH_SYNC: begin
						if (item.byte_value == sync_second_q) begin
							rx_phase = PH_COLLECT;
							res.status = ST_SYNC;
						end else begin
							// the mismatching byte is not retried as a first sync byte
							rx_phase = PH_HUNT;
							res.status = ST_DISCARD;
						end
					end
					PH_COLLECT: begin
						if (wr_pos < STORE_BYTES)
							store_model[wr_pos] = item.byte_value;
						wr_pos++;
						total = wr_pos;
						if (wr_pos > 1 && wr_pos >= int'(store_model[1]) + 2) begin
							rx_phase = PH_DONE;
							wr_pos = 0;
							res.status = ST_COMPLETE;
						end else if (wr_pos >= STORE_BYTES) begin
							// store full before the length was reached: drop the frame
							store_model[1] = '0;
							rx_phase = PH_HUNT;
							wr_pos = 0;
							res.status = ST_OVERFLOW;
						end else begin
							res.status = ST_STORED;
						end
					end
					default: res.status = ST_IGNORED;
				endcase
			end
			REQ_READ: begin
				res.read_data = store_model[item.read_index];
				res.status = ST_READ;
			end
			REQ_RELEASE: begin
				if (rx_phase == PH_DONE) begin
					store_model[1] = '0;
					rx_phase = PH_HUNT;
					wr_pos = 0;
					total = 0;
				end
				res.status = ST_RELEASED;
			end
			default: res.status = ST_IGNORED;
		endcase
		res.frame_total = 7'(total);
		res.frame_ready = (rx_phase == PH_DONE);
		expected_results.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending, status", int'(got.status), -1);
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", int'(got.status), int'(want.status));
			if (got.read_data !== want.read_data)
				report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
			if (got.frame_total !== want.frame_total)
				report_mismatch("frame_total", int'(got.frame_total), int'(want.frame_total));
			if (got.frame_ready !== want.frame_ready)
				report_mismatch("frame_ready", int'(got.frame_ready), int'(want.frame_ready));
		end
	endtask

	// input driver and output back-pressure, both changed on the falling edge
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: sample every transaction on the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SYNC_FIRST:  sync_first_q = cfg_data;
					CFG_SYNC_SECOND: sync_second_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				step_receiver(in_data);
			if (out_valid && out_ready)
				check_result(out_data);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic void push_byte(input logic [7:0] b);
		pending_items.push_back('{req_type: REQ_BYTE, byte_value: b, read_index: 6'($urandom)});
	endfunction

	function automatic void push_read(input logic [5:0] ix);
		pending_items.push_back('{req_type: REQ_READ, byte_value: 8'($urandom), read_index: ix});
	endfunction

	function automatic void push_release();
		pending_items.push_back('{req_type: REQ_RELEASE, byte_value: 8'($urandom),
			read_index: 6'($urandom)});
	endfunction

	// both sync registers, written back to back while the block is idle
	task automatic write_sync(input logic [7:0] first_b, input logic [7:0] second_b);
		gen_first = first_b;
		gen_second = second_b;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= first_b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data <= second_b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every queued transaction has been answered
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// short hand-picked stream: sync corner cases, tiny frames, lock, readback, release
	function automatic void load_directed();
		push_byte(8'h00);
		push_release();                  // release with nothing locked
		pending_items.push_back('{req_type: REQ_UNUSED, byte_value: 8'hFF, read_index: 6'h3F});
		push_byte(gen_first);
		push_byte(gen_first);            // wrong second byte, not retried as a first
		push_byte(gen_second);
		push_byte(gen_first);
		push_byte(gen_second);
		push_byte(8'hFF);                // command
		push_byte(8'd2);                 // length
		push_byte(8'h00);
		push_byte(8'hFF);                // completes the frame
		push_byte(8'h3C);                // ignored while locked
		push_read(6'd0);
		push_read(6'd1);
		push_read(6'd2);
		push_read(6'd3);
		push_release();
		push_read(6'd1);                 // length entry cleared by the release
		push_byte(gen_first);
		push_byte(gen_second);
		push_byte(8'h11);
		push_byte(8'h00);                // zero length: complete after two bytes
		push_release();
	endfunction

	// oversized frame: fills every store entry and is dropped
	function automatic void load_overflow_frame();
		int k;
		push_byte(gen_first);
		push_byte(gen_second);
		push_byte(8'($urandom));
		push_byte(8'($urandom_range(255, 63)));
		for (k = 0; k < STORE_BYTES - 2; k++)
			push_byte(8'($urandom));
	endfunction

	// mostly well-formed frames with random content, some broken syncs and noise
	function automatic void load_random(input int n);
		int len;
		int data_n;
		int pick;
		int k;
		logic [7:0] b;
		while (pending_items.size() < n) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				push_byte(gen_first);
				push_byte(gen_second);
				push_byte(8'($urandom));
				pick = $urandom_range(99);
				if (pick < 80)
					len = $urandom_range(12);
				else if (pick < 90)
					len = $urandom_range(62, 13);
				else
					len = $urandom_range(255, 63);
				push_byte(8'(len));
				data_n = (len > STORE_BYTES - 2) ? STORE_BYTES - 2 : len;
				for (k = 0; k < data_n; k++) begin
					if ($urandom_range(19) == 0)
						push_read(6'($urandom));
					push_byte(8'($urandom));
				end
				if (len <= STORE_BYTES - 2) begin
					repeat ($urandom_range(2)) push_byte(8'($urandom));
					repeat ($urandom_range(2)) push_read(6'($urandom_range(len + 1)));
					// now and then the frame stays locked into the next sequence
					if ($urandom_range(29) != 0)
						push_release();
				end
			end else if (pick < 80) begin
				b = 8'($urandom);
				if (b == gen_second)
					b = ~b;
				push_byte(gen_first);
				push_byte(b);
			end else begin
				pending_items.push_back(in_item_t'(16'($urandom)));
			end
		end
	endfunction

	initial begin
		int chunk;
		logic [7:0] same_b;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
		load_directed();
		drain();

		for (chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
			case (chunk / 2)
				0: begin
					send_gap_pct = 37;
					recv_stall_pct = 80;
				end
				1: begin
					send_gap_pct = 80;
					recv_stall_pct = 37;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (chunk)
				0: write_sync(8'hFF, 8'h00);
				1: write_sync(8'h00, 8'hFF);
				3: begin
					same_b = 8'($urandom);
					write_sync(same_b, same_b);
				end
				4: write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
				default: write_sync(8'($urandom), 8'($urandom));
			endcase
			// every store entry gets written before any random read
			if (chunk == 0)
				load_overflow_frame();
			load_random(CHUNK_ITEMS);
			drain();
		end

		repeat (PIPE_DEPTH + 6) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
